### src/mqed_pkg.sv
// ----------------------------------------------------------------------------
// mqed_pkg
// Shared types, constants and the quadrature transition table for the
// multi-encoder quadrature decoder.
// ----------------------------------------------------------------------------
package mqed_pkg;

    localparam int unsigned IndexWidth = 5;
    localparam int unsigned PairWidth  = 2;
    localparam int unsigned CountWidth = 4;
    localparam int unsigned StepWidth  = 2;

    // Pulse count value after reset and after every emitted step.
    localparam logic [CountWidth-1:0] PULSE_RESET = 4'd8;

    // Step codes on the result channel.
    localparam logic signed [StepWidth-1:0] STEP_NONE = 2'sb00;
    localparam logic signed [StepWidth-1:0] STEP_CW   = 2'sb01;
    localparam logic signed [StepWidth-1:0] STEP_CCW  = 2'sb11;

    // Per-encoder state word as it sits in the state memory.
    typedef struct packed {
        logic [PairWidth-1:0]  pair;
        logic [CountWidth-1:0] count;
        logic                  dir;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{pair: 2'b00, count: PULSE_RESET, dir: 1'b0};

    // Standard quadrature table indexed by {old pair, new pair}. Returns +1 for
    // the 00-01-11-10 order, -1 for the reverse, 0 for no or invalid change.
    function automatic logic signed [StepWidth-1:0] quad_delta(
        input logic [2*PairWidth-1:0] code
    );
        logic signed [StepWidth-1:0] d;
        begin
            unique case (code)
                4'b0001, 4'b0111, 4'b1000, 4'b1110: d = STEP_CW;
                4'b0010, 4'b0100, 4'b1011, 4'b1101: d = STEP_CCW;
                default:                            d = STEP_NONE;
            endcase
            return d;
        end
    endfunction

endpackage

### src/multi_quadrature_encoder_decoder_top.sv
// ----------------------------------------------------------------------------
// multi_quadrature_encoder_decoder_top
// Decodes the scanned A/B samples of many quadrature encoders into detent
// steps, keeping each encoder's state in a small synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready) carries one sample per transfer:
// an encoder index and that encoder's sampled A/B pair. The result channel
// (o_out_valid / i_out_ready) returns exactly one step per sample, in the same
// order: +1 clockwise, -1 counterclockwise, 0 for no step.
// A transferred sample is loaded into the compute stage while its state is
// read, then into the result register, from which its step transfers.
// Throughput: one sample per clock cycle while the receiver is ready,
// including back-to-back samples for the same encoder; each sample makes a
// single read-modify-write of the state memory, whose read is registered and
// whose write-back is forwarded to a following sample of the same encoder.
// Reset (synchronous, active low) empties the pipeline and clears the per-entry
// valid bits at once, so every encoder reads as pair 00, count 8, direction 0
// right after reset with no clearing pass. No sample is taken during reset.
// When the receiver stalls, the result register holds its step and the one
// sample in flight waits in the compute stage; a new sample is still taken
// as long as the compute stage can move on into the result register.
// Samples whose index is at or above ENCODERS leave all state unchanged and
// return a step of 0.
// ----------------------------------------------------------------------------
module multi_quadrature_encoder_decoder_top #(
    parameter int unsigned ENCODERS    = 32,
    parameter int unsigned STEP_PULSES = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [mqed_pkg::IndexWidth-1:0]        i_encoder_index,
    input  logic [mqed_pkg::PairWidth-1:0]         i_ab_pair,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [mqed_pkg::StepWidth-1:0]  o_step
);
    import mqed_pkg::*;

    // Only indices that fit in the input field can ever be stored.
    localparam int unsigned IndexSpan = 1 << IndexWidth;
    localparam int unsigned Depth     = (ENCODERS < IndexSpan) ? ENCODERS : IndexSpan;
    localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;

    // State memory and its per-entry valid bits. An entry that was never
    // written reads as the reset state.
    t_entry r_mem [Depth];
    logic   r_vld [Depth];

    // Memory read port output, registered.
    t_entry r_rd_entry;
    logic   r_rd_vld;

    // Compute stage: holds the sample whose state is being read.
    logic                 r_s1_valid;
    logic [AddrWidth-1:0] r_s1_addr;
    logic [PairWidth-1:0] r_s1_pair;
    logic                 r_s1_inrange;

    // Last entry written back, kept for forwarding.
    logic                 r_wb_valid;
    logic [AddrWidth-1:0] r_wb_addr;
    t_entry               r_wb_entry;

    // Result register.
    logic                        r_out_valid;
    logic signed [StepWidth-1:0] r_out_step;

    logic                        in_fire;
    logic                        s1_fire;
    logic                        in_range;
    logic [AddrWidth-1:0]        rd_addr;
    t_entry                      cur_entry;
    t_entry                      n_entry;
    logic signed [StepWidth-1:0] delta;
    logic signed [StepWidth-1:0] n_step;
    logic [CountWidth-1:0]       moved_count;
    logic                        moved_dir;
    logic [(1<<CountWidth)-1:0]  is_multiple;

    // Which count values are a multiple of STEP_PULSES, settled at elaboration.
    for (genvar g = 0; g < (1 << CountWidth); g++) begin : g_mult
        assign is_multiple[g] = ((g % STEP_PULSES) == 0);
    end

    // The compute stage moves on whenever the result register is free or
    // is being emptied in this cycle. Nothing is taken while reset is held.
    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_s1_valid || s1_fire);
    assign in_fire    = i_in_valid && o_in_ready;

    assign in_range = (32'(i_encoder_index) < ENCODERS);
    assign rd_addr  = in_range ? i_encoder_index[AddrWidth-1:0] : '0;

    // Read-modify-write of one encoder's state.
    always_comb begin
        // A write to the same entry at the edge of the read is not yet seen by
        // the memory output, so take it from the write-back register instead.
        if (r_wb_valid && (r_wb_addr == r_s1_addr)) begin
            cur_entry = r_wb_entry;
        end else if (r_rd_vld) begin
            cur_entry = r_rd_entry;
        end else begin
            cur_entry = ENTRY_RESET;
        end

        delta       = quad_delta({cur_entry.pair, r_s1_pair});
        moved_dir   = (delta == STEP_CW);
        moved_count = moved_dir ? (cur_entry.count + 4'd1) : (cur_entry.count + 4'd15);

        n_entry      = cur_entry;
        n_entry.pair = r_s1_pair;
        n_step       = STEP_NONE;

        if (delta != STEP_NONE) begin
            n_entry.count = moved_count;
            n_entry.dir   = moved_dir;
            // A step needs the same direction as the previous pulse and a
            // count that lands on a multiple of the pulses per detent.
            if ((cur_entry.dir == moved_dir) && is_multiple[moved_count]) begin
                n_entry.count = PULSE_RESET;
                n_step        = moved_dir ? STEP_CW : STEP_CCW;
            end
        end

        if (!r_s1_inrange) begin
            n_step = STEP_NONE;
        end
    end

    // Memory read and write ports; no reset on the storage itself.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_entry <= r_mem[rd_addr];
        end
        if (s1_fire && r_s1_inrange) begin
            r_mem[r_s1_addr] <= n_entry;
        end
    end

    // Valid bits: cleared at reset, set on the first write to an entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Depth; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (in_fire) begin
                r_rd_vld <= r_vld[rd_addr];
            end
            if (s1_fire && r_s1_inrange) begin
                r_vld[r_s1_addr] <= 1'b1;
            end
        end
    end

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire && r_s1_inrange) begin
                r_wb_valid <= 1'b1;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_addr    <= rd_addr;
            r_s1_pair    <= i_ab_pair;
            r_s1_inrange <= in_range;
        end
        if (s1_fire && r_s1_inrange) begin
            r_wb_addr  <= r_s1_addr;
            r_wb_entry <= n_entry;
        end
        if (s1_fire) begin
            r_out_step <= n_step;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_step      = r_out_step;

endmodule

### sim/mqed_step_checker.sv
// ----------------------------------------------------------------------------
// mqed_step_checker
// Watches both channels of the quadrature decoder, predicts the detent step
// of every transferred sample from its own copy of the per-encoder state, and
// compares each result transfer against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mqed_step_checker #(
    parameter int unsigned ENCODERS    = 32,
    parameter int unsigned STEP_PULSES = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic [mqed_pkg::IndexWidth-1:0]        i_encoder_index,
    input  logic [mqed_pkg::PairWidth-1:0]         i_ab_pair,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic signed [mqed_pkg::StepWidth-1:0]  i_step,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mqed_pkg::*;

    // Mismatch lines beyond this many are counted but not printed.
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [31:0]                 seq;
        logic [IndexWidth-1:0]       idx;
        logic signed [StepWidth-1:0] step;
    } t_step_exp;

    logic [PairWidth-1:0]  enc_pair  [ENCODERS];
    logic [CountWidth-1:0] enc_count [ENCODERS];
    logic                  enc_cw    [ENCODERS];

    t_step_exp   expected_steps[$];
    int          mismatches = 0;
    int unsigned sample_seq = 0;

    // Position of a pair along the clockwise Gray ring 00, 01, 11, 10.
    function automatic logic [1:0] ring_pos(input logic [PairWidth-1:0] p);
        return {p[1], p[1] ^ p[0]};
    endfunction

    // Applies one sample to the shadow state and returns the step it causes.
    function automatic logic signed [StepWidth-1:0] decode_sample(
        input logic [IndexWidth-1:0] idx,
        input logic [PairWidth-1:0]  pair
    );
        logic [1:0]            hop;
        logic                  cw;
        logic                  was_cw;
        logic [CountWidth-1:0] cnt;
        if (int'(idx) >= int'(ENCODERS))
            return STEP_NONE;
        hop = ring_pos(pair) - ring_pos(enc_pair[idx]);
        enc_pair[idx] = pair;
        // A hop of zero is no change, a hop of two is a double (invalid) change.
        if (hop == 2'd0 || hop == 2'd2)
            return STEP_NONE;
        cw = (hop == 2'd1);
        cnt = cw ? enc_count[idx] + 1'b1 : enc_count[idx] - 1'b1;
        enc_count[idx] = cnt;
        was_cw = enc_cw[idx];
        enc_cw[idx] = cw;
        if (was_cw != cw)
            return STEP_NONE;
        if ((cnt % STEP_PULSES) != 0)
            return STEP_NONE;
        enc_count[idx] = PULSE_RESET;
        return cw ? STEP_CW : STEP_CCW;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch: %s", msg);
    endtask

    always @(posedge i_clk) begin
        t_step_exp head;
        int        e;
        if (!i_rst_n) begin
            for (e = 0; e < int'(ENCODERS); e++) begin
                enc_pair[e]  = '0;
                enc_count[e] = PULSE_RESET;
                enc_cw[e]    = 1'b0;
            end
            expected_steps.delete();
            sample_seq = 0;
        end else begin
            // A result can never leave in the same cycle its sample arrives,
            // so the result side is settled first.
            if (i_out_valid && i_out_ready) begin
                if (expected_steps.size() == 0) begin
                    report_mismatch("result transfer with no sample outstanding");
                end else begin
                    head = expected_steps.pop_front();
                    if (i_step !== head.step)
                        report_mismatch($sformatf(
                            "sample %0d encoder %0d: step %0d, expected %0d",
                            head.seq, head.idx, i_step, head.step));
                end
            end
            if (i_in_valid && i_in_ready) begin
                head.seq  = sample_seq;
                head.idx  = i_encoder_index;
                head.step = decode_sample(i_encoder_index, i_ab_pair);
                expected_steps.push_back(head);
                sample_seq++;
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_steps.size();
    end

endmodule

### sim/tb_multi_quadrature_encoder_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_multi_quadrature_encoder_decoder_top
// Drives scanned A/B samples into the multi-encoder quadrature decoder: a
// directed opening that turns encoders both ways and walks every transition,
// then random rotation sequences mixed with idle, invalid and random samples,
// under random sender gaps and receiver stalls. A checker beside the block
// predicts and compares every step; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_multi_quadrature_encoder_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mqed_pkg::*;

    localparam int unsigned ENCODERS    = 32;
    localparam int unsigned STEP_PULSES = 4;

    // Percentage of cycles in which either side idles while idling is enabled.
    localparam int unsigned IDLE_PCT    = 29;
    // Cycles without any transfer before the run is declared hung.
    localparam int          STALL_LIMIT = 1000;
    // Cycles allowed after the last result for anything stray to show up.
    localparam int          TAIL_CYCLES = 4;

    // Walk through all sixteen {old, new} pair combinations, starting from
    // the reset pair 00: 0,1,1,2,2,3,3,0,2,0,3,1,3,2,1,0 read from the top.
    localparam logic [31:0] TRANSITION_WALK = 32'b00_01_01_10_10_11_11_00_10_00_11_01_11_10_01_00;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [IndexWidth-1:0]        i_encoder_index;
    logic [PairWidth-1:0]         i_ab_pair;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic signed [StepWidth-1:0]  o_step;

    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;

    // When low, neither side idles; used for a long full-rate stretch.
    logic idle_on;

    // Stimulus-side view of each encoder: the last pair sent and the way the
    // shaft is currently being turned. Only used to build sequences.
    logic [PairWidth-1:0] sent_pair [ENCODERS];
    logic                 turning_cw [ENCODERS];

    multi_quadrature_encoder_decoder_top #(
        .ENCODERS    (ENCODERS),
        .STEP_PULSES (STEP_PULSES)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_encoder_index (i_encoder_index),
        .i_ab_pair       (i_ab_pair),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_step          (o_step)
    );

    mqed_step_checker #(
        .ENCODERS    (ENCODERS),
        .STEP_PULSES (STEP_PULSES)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_encoder_index (i_encoder_index),
        .i_ab_pair       (i_ab_pair),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_step          (o_step),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random while idling is enabled and is always
    // ready during the full-rate stretch.
    always @(posedge i_clk) begin
        if (idle_on)
            i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
        else
            i_out_ready <= 1'b1;
    end

    // The watchdog restarts on every transfer on either channel. If nothing
    // moves until the quiet count reaches STALL_LIMIT, the block is hung.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Next pair one quarter cycle along the Gray ring in the given direction.
    function automatic logic [PairWidth-1:0] next_pair(
        input logic [PairWidth-1:0] p,
        input logic                 cw
    );
        logic [1:0] pos;
        pos = {p[1], p[1] ^ p[0]};
        pos = cw ? pos + 2'd1 : pos - 2'd1;
        return {pos[1], pos[1] ^ pos[0]};
    endfunction

    // Offers one sample and returns at the clock edge where it transfers.
    // Any gap comes first, so valid is only ever lowered between samples and
    // stays high back to back when no gap is drawn.
    task automatic send_sample(
        input logic [IndexWidth-1:0] idx,
        input logic [PairWidth-1:0]  pair
    );
        while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_encoder_index <= idx;
        i_ab_pair       <= pair;
        do
            @(posedge i_clk);
        while (!(i_in_valid && o_in_ready));
        sent_pair[idx] = pair;
    endtask

    // Random samples. Most are well-formed quarter steps in the direction
    // the encoder is being turned, so counts build up to full detents; the
    // rest repeat the pair, jump two positions (invalid), or are random.
    // Half the traffic goes to a few encoders so sequences stay long, while
    // the rest spreads over every index including the top one.
    task automatic run_random(input int count);
        int                    n;
        int unsigned           sel;
        int unsigned           kind;
        logic [IndexWidth-1:0] idx;
        logic [PairWidth-1:0]  pair;
        for (n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 50)
                idx = IndexWidth'($urandom_range(3));
            else if (sel < 60)
                idx = IndexWidth'(ENCODERS - 1);
            else
                idx = IndexWidth'($urandom_range(ENCODERS - 1));
            // Occasionally the shaft is turned back, giving direction reversals.
            if ($urandom_range(99) < 8)
                turning_cw[idx] = ~turning_cw[idx];
            kind = $urandom_range(99);
            if (kind < 72)
                pair = next_pair(sent_pair[idx], turning_cw[idx]);
            else if (kind < 84)
                pair = sent_pair[idx];
            else if (kind < 92)
                pair = sent_pair[idx] ^ 2'b11;
            else
                pair = PairWidth'($urandom_range(3));
            send_sample(idx, pair);
        end
    endtask

    // Holds the sender off until every outstanding step has been returned.
    // The first edge is always waited for, so a sample that transferred at
    // the calling edge is already counted as outstanding.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int e;
        int k;

        // Every input is at a known value before the first clock edge.
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_encoder_index <= '0;
        i_ab_pair       <= '0;
        i_out_ready     <= 1'b0;
        idle_on          = 1'b1;
        for (e = 0; e < int'(ENCODERS); e++) begin
            sent_pair[e]  = '0;
            turning_cw[e] = 1'($urandom_range(1));
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Encoder 0 turns clockwise one full detent twice. The first pulse
        // reverses the reset direction, so the first step comes on the fourth
        // sample; the second detent starts from the reloaded count.
        for (k = 0; k < 2; k++) begin
            send_sample(5'd0, 2'b01);
            send_sample(5'd0, 2'b11);
            send_sample(5'd0, 2'b10);
            send_sample(5'd0, 2'b00);
        end

        // The highest encoder turns counterclockwise, the reset direction, so
        // the count falls from 8 to 4 and a step comes without a reversal.
        send_sample(IndexWidth'(ENCODERS - 1), 2'b10);
        send_sample(IndexWidth'(ENCODERS - 1), 2'b11);
        send_sample(IndexWidth'(ENCODERS - 1), 2'b01);
        send_sample(IndexWidth'(ENCODERS - 1), 2'b00);

        // Encoder 5 goes through every transition once: no change, both
        // quarter steps from each pair, and every invalid double change.
        for (k = 15; k >= 0; k--)
            send_sample(5'd5, TRANSITION_WALK[2*k +: 2]);

        run_random(400);

        // The sender waits here until the block has returned everything.
        drain_results();

        // A long stretch at full rate on both sides.
        idle_on = 1'b0;
        run_random(300);
        idle_on = 1'b1;

        run_random(418);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
